FILE: design/ept_pkg.sv
// Package for the Euler pose to rigid transform unit.
// Holds widths, CORDIC constants, the arctan table and the shared payload types.
// Depends on nothing.
`default_nettype none
package ept_pkg;
	localparam int CordicSteps = 28;
	localparam logic signed [33:0] CordicX0 = 34'sd652032874;
	localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
	localparam logic signed [35:0] TwoPiQ30 = 36'sd6746518852;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [31:0] DofScaleReset = 32'sd16777216;

	typedef logic [1:0] req_type_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] out_tx;
		logic signed [31:0] out_ty;
		logic signed [31:0] out_tz;
	} xform_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		logic rot_order_yxz;
		logic rotate_trans;
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
		logic signed [35:0] z0;
		logic signed [35:0] z1;
		logic signed [35:0] z2;
		logic flip0;
		logic flip1;
		logic flip2;
	} work_t;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0: atan_q30 = 36'sd843314856;
			5'd1: atan_q30 = 36'sd497837829;
			5'd2: atan_q30 = 36'sd263043836;
			5'd3: atan_q30 = 36'sd133525158;
			5'd4: atan_q30 = 36'sd67021686;
			5'd5: atan_q30 = 36'sd33543515;
			5'd6: atan_q30 = 36'sd16775850;
			5'd7: atan_q30 = 36'sd8388437;
			5'd8: atan_q30 = 36'sd4194282;
			5'd9: atan_q30 = 36'sd2097149;
			5'd10: atan_q30 = 36'sd1048575;
			5'd11: atan_q30 = 36'sd524287;
			5'd12: atan_q30 = 36'sd262143;
			5'd13: atan_q30 = 36'sd131071;
			5'd14: atan_q30 = 36'sd65535;
			5'd15: atan_q30 = 36'sd32767;
			5'd16: atan_q30 = 36'sd16383;
			5'd17: atan_q30 = 36'sd8191;
			5'd18: atan_q30 = 36'sd4095;
			5'd19: atan_q30 = 36'sd2047;
			5'd20: atan_q30 = 36'sd1023;
			5'd21: atan_q30 = 36'sd511;
			5'd22: atan_q30 = 36'sd255;
			5'd23: atan_q30 = 36'sd127;
			5'd24: atan_q30 = 36'sd63;
			5'd25: atan_q30 = 36'sd31;
			5'd26: atan_q30 = 36'sd15;
			5'd27: atan_q30 = 36'sd7;
			default: atan_q30 = 36'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// Rounded product with half-up rounding at bit 30, operands up to 34 bits.
	function automatic logic signed [67:0] mul30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b;
		p = p + 68'sd536870912;
		mul30 = p >>> 30;
	endfunction
endpackage
`default_nettype wire

FILE: design/ept_if.sv
// Valid/ready channel interfaces for the pose, result and configuration transfers.
// Depends on ept_pkg.
`default_nettype none
interface ept_pose_if;
	import ept_pkg::*;
	logic valid;
	logic ready;
	pose_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ept_xform_if;
	import ept_pkg::*;
	logic valid;
	logic ready;
	xform_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ept_cfg_if;
	logic valid;
	logic ready;
	logic signed [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/euler_pose_to_rigid_transform_unit.sv
// Top level of the Euler pose to rigid transform unit.
// Depends on ept_pkg, ept_if, ept_front, ept_fifo and ept_back.
//
// Channel   Direction  Carries
// pose      in         req_type, translations, angles
// xform     out        m00..m22, out_tx, out_ty, out_tz
// cfg       in         dof_scale
//
// One pose is accepted per cycle while the front part is not stalled. Items pass
// through the front part, the queue and the back part with its 28-step CORDIC.
// Reset clears all valid flags and sets dof_scale to 1.0.
// The back part stalls as a whole when its result is not taken; the queue
// lets the front part keep going until it fills.
`default_nettype none
module euler_pose_to_rigid_transform_unit
	import ept_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	ept_pose_if.sink pose,
	ept_xform_if.source xform,
	ept_cfg_if.sink cfg
);
	logic signed [31:0] dof_scale_q;
	logic fv, fr, qv, qr;
	work_t fd, qd;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dof_scale_q <= DofScaleReset;
		end else if (cfg.valid) begin
			dof_scale_q <= cfg.data;
		end
	end

	ept_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pose.valid), .in_ready(pose.ready), .in_data(pose.data),
		.dof_scale(dof_scale_q),
		.out_valid(fv), .out_ready(fr), .out_data(fd)
	);

	ept_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fv), .in_ready(fr), .in_data(fd),
		.out_valid(qv), .out_ready(qr), .out_data(qd)
	);

	ept_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(qv), .in_ready(qr), .in_data(qd),
		.out_valid(xform.valid), .out_ready(xform.ready), .out_data(xform.data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		xform.valid && !xform.ready |=> xform.valid)
		else $error("Result lost while stalled.");
	assert property (@(posedge clk) disable iff (!arst_n)
		fv && !fr |=> fv && $stable(fd))
		else $error("Front item changed while the queue was full.");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> dof_scale_q == $past(cfg.data))
		else $error("Scale register not written.");
endmodule
`default_nettype wire

FILE: design/ept_front.sv
// Front part: scales the pose, reduces the angles and classifies the request.
// Two pipeline stages; depends on ept_pkg.
`default_nettype none
module ept_front
	import ept_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pose_t in_data,
	input wire logic signed [31:0] dof_scale,
	output logic out_valid,
	input wire logic out_ready,
	output work_t out_data
);
	logic v_s1, v_s2;
	logic [1:0] mode_s1;
	logic signed [31:0] sc_s1 [6];
	work_t w_s2;
	logic adv1, adv2;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	function automatic logic signed [31:0] scale(input logic signed [31:0] v,
			input logic signed [31:0] s);
		logic signed [63:0] p;
		logic signed [71:0] r;
		p = v * s;
		r = (72'(p) + 72'sd8388608) >>> 24;
		scale = sat32(r);
	endfunction

	// Reduction of a Q3.28 angle: in Q.30 it stays below 8, under 3 pi, so at most two wraps.
	function automatic logic signed [36:0] reduce(input logic signed [31:0] a);
		logic signed [35:0] z;
		logic f;
		z = 36'(a) <<< 2;
		if (z > PiQ30) z = z - TwoPiQ30;
		if (z > PiQ30) z = z - TwoPiQ30;
		if (z < -PiQ30) z = z + TwoPiQ30;
		if (z < -PiQ30) z = z + TwoPiQ30;
		f = 1'b0;
		if (z > HalfPiQ30) begin
			z = z - PiQ30;
			f = 1'b1;
		end else if (z < -HalfPiQ30) begin
			z = z + PiQ30;
			f = 1'b1;
		end
		reduce = {f, z};
	endfunction

	logic signed [36:0] r0, r1, r2;
	assign r0 = reduce(sc_s1[3]);
	assign r1 = reduce(sc_s1[4]);
	assign r2 = reduce(sc_s1[5]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			mode_s1 <= in_data.req_type;
			sc_s1[0] <= scale(in_data.trans_x, dof_scale);
			sc_s1[1] <= scale(in_data.trans_y, dof_scale);
			sc_s1[2] <= scale(in_data.trans_z, dof_scale);
			sc_s1[3] <= scale(in_data.rot_x, dof_scale);
			sc_s1[4] <= scale(in_data.rot_y, dof_scale);
			sc_s1[5] <= scale(in_data.rot_z, dof_scale);
		end
		if (adv2 && v_s1) begin
			w_s2.rot_order_yxz <= mode_s1[0];
			w_s2.rotate_trans <= (mode_s1 == 2'd0) || (mode_s1 == 2'd3);
			w_s2.t0 <= sc_s1[0];
			w_s2.t1 <= sc_s1[1];
			w_s2.t2 <= sc_s1[2];
			w_s2.flip0 <= r0[36];
			w_s2.z0 <= r0[35:0];
			w_s2.flip1 <= r1[36];
			w_s2.z1 <= r1[35:0];
			w_s2.flip2 <= r2[36];
			w_s2.z2 <= r2[35:0];
		end
	end

	assign out_valid = v_s2;
	assign out_data = w_s2;
endmodule
`default_nettype wire

FILE: design/ept_fifo.sv
// Short queue between the front and back parts, four entries deep.
// Depends on ept_pkg.
`default_nettype none
module ept_fifo
	import ept_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire work_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output work_t out_data
);
	work_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 3'd4;
	assign out_valid = cnt_q != 3'd0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end
endmodule
`default_nettype wire

FILE: design/ept_back.sv
// Back part: pipelined CORDIC for three angles, matrix products and translation.
// One CORDIC step per stage; depends on ept_pkg.
`default_nettype none
module ept_back
	import ept_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire work_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output xform_t out_data
);
	localparam int NStg = CordicSteps + 6;

	logic vld_q [1:NStg];
	logic adv;
	assign adv = !vld_q[NStg] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NStg; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[1] <= in_valid;
			for (int i = 2; i <= NStg; i++) vld_q[i] <= vld_q[i - 1];
		end
	end

	// CORDIC pipeline, three lanes.
	logic signed [33:0] cx_q [1:CordicSteps][3];
	logic signed [33:0] cy_q [1:CordicSteps][3];
	logic signed [35:0] cz_q [1:CordicSteps][3];
	work_t wk_q [1:CordicSteps];
	logic signed [33:0] cx_in [CordicSteps][3];
	logic signed [33:0] cy_in [CordicSteps][3];
	logic signed [35:0] cz_in [CordicSteps][3];
	work_t wk_in [CordicSteps];

	always_comb begin
		cz_in[0][0] = in_data.z0;
		cz_in[0][1] = in_data.z1;
		cz_in[0][2] = in_data.z2;
		for (int l = 0; l < 3; l++) begin
			cx_in[0][l] = CordicX0;
			cy_in[0][l] = '0;
		end
		wk_in[0] = in_data;
		for (int s = 1; s < CordicSteps; s++) begin
			wk_in[s] = wk_q[s];
			for (int l = 0; l < 3; l++) begin
				cx_in[s][l] = cx_q[s][l];
				cy_in[s][l] = cy_q[s][l];
				cz_in[s][l] = cz_q[s][l];
			end
		end
	end

	for (genvar s = 0; s < CordicSteps; s++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				wk_q[s + 1] <= wk_in[s];
				for (int l = 0; l < 3; l++) begin
					if (cz_in[s][l] >= 0) begin
						cx_q[s + 1][l] <= cx_in[s][l] - (cy_in[s][l] >>> s);
						cy_q[s + 1][l] <= cy_in[s][l] + (cx_in[s][l] >>> s);
						cz_q[s + 1][l] <= cz_in[s][l] - atan_q30(5'(s));
					end else begin
						cx_q[s + 1][l] <= cx_in[s][l] + (cy_in[s][l] >>> s);
						cy_q[s + 1][l] <= cy_in[s][l] - (cx_in[s][l] >>> s);
						cz_q[s + 1][l] <= cz_in[s][l] + atan_q30(5'(s));
					end
				end
			end
		end
	end

	// Stage A: apply flips.
	logic signed [33:0] sa_a, ca_a, sb_a, cb_a, sc_a, cc_a;
	work_t wk_a;
	logic [2:0] flp;
	assign flp = {wk_q[CordicSteps].flip2, wk_q[CordicSteps].flip1,
		wk_q[CordicSteps].flip0};

	always_ff @(posedge clk) begin
		if (adv) begin
			wk_a <= wk_q[CordicSteps];
			sa_a <= flp[0] ? -cy_q[CordicSteps][0] : cy_q[CordicSteps][0];
			ca_a <= flp[0] ? -cx_q[CordicSteps][0] : cx_q[CordicSteps][0];
			sb_a <= flp[1] ? -cy_q[CordicSteps][1] : cy_q[CordicSteps][1];
			cb_a <= flp[1] ? -cx_q[CordicSteps][1] : cx_q[CordicSteps][1];
			sc_a <= flp[2] ? -cy_q[CordicSteps][2] : cy_q[CordicSteps][2];
			cc_a <= flp[2] ? -cx_q[CordicSteps][2] : cx_q[CordicSteps][2];
		end
	end

	// Stage B: pair products.
	logic signed [33:0] sxsy_b, cycz_b, cysz_b, casb_b, casc_b, cacc_b, cacb_b, sbsc_b;
	logic signed [33:0] sa_b, sb_b, sc_b, cc_b;
	work_t wk_b;
	always_ff @(posedge clk) begin
		if (adv) begin
			wk_b <= wk_a;
			sxsy_b <= 34'(mul30(sa_a, sb_a));
			cycz_b <= 34'(mul30(cb_a, cc_a));
			cysz_b <= 34'(mul30(cb_a, sc_a));
			casb_b <= 34'(mul30(ca_a, sb_a));
			casc_b <= 34'(mul30(ca_a, sc_a));
			cacc_b <= 34'(mul30(ca_a, cc_a));
			cacb_b <= 34'(mul30(ca_a, cb_a));
			sbsc_b <= 34'(mul30(sb_a, sc_a));
			sa_b <= sa_a;
			sb_b <= sb_a;
			sc_b <= sc_a;
			cc_b <= cc_a;
		end
	end

	// Stage C: triple products and matrix assembly.
	logic signed [31:0] m_c [9];
	work_t wk_c;
	logic signed [35:0] pxsc, pxcc, pysa, pcsb, pzsa;
	always_comb begin
		pxsc = 36'(mul30(sxsy_b, sc_b));
		pxcc = 36'(mul30(sxsy_b, cc_b));
		pysa = 36'(mul30(cysz_b, sa_b));
		pcsb = 36'(mul30(cc_b, sb_b));
		pzsa = 36'(mul30(cycz_b, sa_b));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wk_c <= wk_b;
			m_c[4] <= sat32(72'(cacc_b));
			m_c[8] <= sat32(72'(cacb_b));
			if (!wk_b.rot_order_yxz) begin
				m_c[0] <= sat32(72'(cycz_b) + 72'(pxsc));
				m_c[1] <= sat32(72'(pxcc) - 72'(cysz_b));
				m_c[2] <= sat32(72'(casb_b));
				m_c[3] <= sat32(72'(casc_b));
				m_c[5] <= sat32(-72'(sa_b));
				m_c[6] <= sat32(72'(pysa) - 72'(pcsb));
				m_c[7] <= sat32(72'(sbsc_b) + 72'(pzsa));
			end else begin
				m_c[0] <= sat32(72'(cycz_b) - 72'(pxsc));
				m_c[1] <= sat32(-72'(casc_b));
				m_c[2] <= sat32(72'(pcsb) + 72'(pysa));
				m_c[3] <= sat32(72'(cysz_b) + 72'(pxcc));
				m_c[5] <= sat32(72'(sbsc_b) - 72'(pzsa));
				m_c[6] <= sat32(-72'(casb_b));
				m_c[7] <= sat32(72'(sa_b));
			end
		end
	end

	// Stage D: matrix times translation products.
	logic signed [31:0] m_d [9];
	logic signed [35:0] p_d [9];
	work_t wk_d;
	always_ff @(posedge clk) begin
		if (adv) begin
			wk_d <= wk_c;
			m_d <= m_c;
			for (int i = 0; i < 3; i++) begin
				p_d[3 * i] <= 36'(mul30(34'(m_c[3 * i]), 34'(wk_c.t0)));
				p_d[3 * i + 1] <= 36'(mul30(34'(m_c[3 * i + 1]), 34'(wk_c.t1)));
				p_d[3 * i + 2] <= 36'(mul30(34'(m_c[3 * i + 2]), 34'(wk_c.t2)));
			end
		end
	end

	// Stage E: sums and output register.
	xform_t res_e;
	logic signed [31:0] tr [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tr[i] = sat32(72'(p_d[3 * i]) + 72'(p_d[3 * i + 1]) + 72'(p_d[3 * i + 2]));
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_e.m00 <= m_d[0];
			res_e.m01 <= m_d[1];
			res_e.m02 <= m_d[2];
			res_e.m10 <= m_d[3];
			res_e.m11 <= m_d[4];
			res_e.m12 <= m_d[5];
			res_e.m20 <= m_d[6];
			res_e.m21 <= m_d[7];
			res_e.m22 <= m_d[8];
			res_e.out_tx <= wk_d.rotate_trans ? tr[0] : wk_d.t0;
			res_e.out_ty <= wk_d.rotate_trans ? tr[1] : wk_d.t1;
			res_e.out_tz <= wk_d.rotate_trans ? tr[2] : wk_d.t2;
		end
	end

	// Stages: CORDIC 28, then A, B, C, D, E, then the output register.
	xform_t res_f;
	always_ff @(posedge clk) begin
		if (adv) res_f <= res_e;
	end

	assign out_valid = vld_q[NStg];
	assign out_data = res_f;
endmodule
`default_nettype wire
